### design/fcs_pkg.sv
// shared types and constants for the fastq composition statistics block
package fcs_pkg;

    localparam int COUNT_BITS = 40;
    localparam int LEN_BITS   = 32;
    localparam int PHRED_BITS = 7;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = QPTR_W + 1;

    localparam logic       CMD_DATA = 1'b0;
    localparam logic       CMD_END  = 1'b1;

    localparam logic [7:0] CH_NL = 8'd10;
    localparam logic [7:0] CH_CR = 8'd13;
    localparam logic [7:0] CH_A  = 8'd65;
    localparam logic [7:0] CH_C  = 8'd67;
    localparam logic [7:0] CH_G  = 8'd71;
    localparam logic [7:0] CH_T  = 8'd84;

    localparam logic [7:0] QUAL_LOW_INIT   = 8'd104;
    localparam logic [7:0] QUAL_HIGH_INIT  = 8'd33;
    localparam logic [7:0] QUAL_HIGH_LIMIT = 8'd74;
    localparam logic [7:0] QUAL_LOW_LIMIT  = 8'd59;

    localparam logic [PHRED_BITS-1:0] PHRED_NONE = PHRED_BITS'(0);
    localparam logic [PHRED_BITS-1:0] PHRED_33   = PHRED_BITS'(33);
    localparam logic [PHRED_BITS-1:0] PHRED_64   = PHRED_BITS'(64);

    localparam logic [1:0] PHASE_QUAL   = 2'd0;
    localparam logic [1:0] PHASE_HEADER = 2'd1;
    localparam logic [1:0] PHASE_SEQ    = 2'd2;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [LEN_BITS-1:0]   LEN_MAX   = {LEN_BITS{1'b1}};

    typedef enum logic [2:0] {
        OP_A,
        OP_C,
        OP_G,
        OP_T,
        OP_OTHER,
        OP_QUAL,
        OP_QCLOSE,
        OP_END
    } op_kind_t;

    typedef struct packed {
        op_kind_t   kind;
        logic [7:0] data_byte;
        logic       close_qual;
    } op_t;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
    } in_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0] count_a;
        logic [COUNT_BITS-1:0] count_c;
        logic [COUNT_BITS-1:0] count_g;
        logic [COUNT_BITS-1:0] count_t;
        logic [COUNT_BITS-1:0] count_other;
        logic [7:0]            min_quality_char;
        logic [7:0]            max_quality_char;
        logic [LEN_BITS-1:0]   min_quality_len;
        logic [LEN_BITS-1:0]   max_quality_len;
        logic [PHRED_BITS-1:0] phred_offset;
    } out_t;

endpackage

### design/fastq_composition_stats.sv
// top level of the fastq composition statistics block
// Takes one stream byte (or an end request) per clock while full is low: the front end
// classifies each byte by line phase in the accepting cycle, a four-entry queue
// carries the resulting operation to the back end, and the back end updates the
// saturating tallies, quality range and line lengths one operation per cycle unless
// an end request waits for the result register. The back end takes an end request
// from the queue, and registers its totals, only once no earlier result is still
// waiting to be popped. The single result register lets data bytes keep flowing
// while totals wait to be popped; only a second end request stalls behind an
// unpopped result, and full then rises once the queue has filled.
module fastq_composition_stats (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  fcs_pkg::in_t  item,
    output logic          empty,
    input  logic          pop,
    output fcs_pkg::out_t result
);
    import fcs_pkg::*;

    logic q_full;
    logic q_push;
    op_t  q_op;
    logic rd_en;
    logic rd_valid;
    op_t  rd_op;

    fcs_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .item   (item),
        .q_full (q_full),
        .q_push (q_push),
        .q_op   (q_op),
        .full   (full)
    );

    fcs_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_push),
        .wr_op    (q_op),
        .q_full   (q_full),
        .rd_en    (rd_en),
        .rd_valid (rd_valid),
        .rd_op    (rd_op)
    );

    fcs_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_valid (rd_valid),
        .rd_op    (rd_op),
        .rd_en    (rd_en),
        .empty    (empty),
        .pop      (pop),
        .result   (result)
    );

endmodule

### design/fcs_front.sv
// front end: tracks line phase and turns stream bytes into stats operations
module fcs_front (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  fcs_pkg::in_t item,
    input  logic         q_full,
    output logic         q_push,
    output fcs_pkg::op_t q_op,
    output logic         full
);
    import fcs_pkg::*;

    logic [1:0] phase_reg, phase_next;
    logic       pending_reg, pending_next;
    logic       take;

    assign full = q_full;
    assign take = push && !q_full;

    always_comb
    begin
        phase_next   = phase_reg;
        pending_next = pending_reg;
        q_push       = 1'b0;
        q_op.kind       = OP_OTHER;
        q_op.data_byte  = item.data_byte;
        q_op.close_qual = 1'b0;
        if (take)
        begin
            if (item.cmd == CMD_END)
            begin
                q_push          = 1'b1;
                q_op.kind       = OP_END;
                q_op.close_qual = pending_reg && (phase_reg == PHASE_QUAL);
                phase_next      = PHASE_HEADER;
                pending_next    = 1'b0;
            end
            else if (item.data_byte == CH_NL)
            begin
                // only the end of a quality line matters to the back end
                q_push       = (phase_reg == PHASE_QUAL);
                q_op.kind    = OP_QCLOSE;
                phase_next   = phase_reg + 2'd1;
                pending_next = 1'b0;
            end
            else
            begin
                pending_next = 1'b1;
                if (item.data_byte != CH_CR)
                begin
                    if (phase_reg == PHASE_SEQ)
                    begin
                        q_push = 1'b1;
                        case (item.data_byte)
                            CH_A:    q_op.kind = OP_A;
                            CH_C:    q_op.kind = OP_C;
                            CH_G:    q_op.kind = OP_G;
                            CH_T:    q_op.kind = OP_T;
                            default: q_op.kind = OP_OTHER;
                        endcase
                    end
                    else if (phase_reg == PHASE_QUAL)
                    begin
                        q_push    = 1'b1;
                        q_op.kind = OP_QUAL;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PHASE_HEADER;
            pending_reg <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            pending_reg <= pending_next;
        end
    end

    // an end request always leaves the front at the header line with nothing pending
    a_end_resets_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (take && item.cmd == CMD_END) |=> (phase_reg == PHASE_HEADER && !pending_reg))
        else $error("front did not return to header phase after end");

    a_push_needs_take: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> take)
        else $error("operation queued without an accepted request");

    a_close_only_quality: assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && q_op.close_qual) |-> (phase_reg == PHASE_QUAL && pending_reg))
        else $error("quality close flagged outside a pending quality line");

endmodule

### design/fcs_queue.sv
// small operation queue between front and back end
module fcs_queue (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr_en,
    input  fcs_pkg::op_t wr_op,
    output logic         q_full,
    input  logic         rd_en,
    output logic         rd_valid,
    output fcs_pkg::op_t rd_op
);
    import fcs_pkg::*;

    op_t               mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign q_full   = (count_reg == QCNT_W'(QDEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_op    = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_reg + QCNT_W'(wr_en) - QCNT_W'(rd_en);
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("queue count beyond depth");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> rd_valid)
        else $error("queue read while empty");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !q_full)
        else $error("queue write while full");

endmodule

### design/fcs_back.sv
// back end: tallies, quality range, line lengths and the result register
module fcs_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          rd_valid,
    input  fcs_pkg::op_t  rd_op,
    output logic          rd_en,
    output logic          empty,
    input  logic          pop,
    output fcs_pkg::out_t result
);
    import fcs_pkg::*;

    logic [COUNT_BITS-1:0] tally_a_reg, tally_a_next;
    logic [COUNT_BITS-1:0] tally_c_reg, tally_c_next;
    logic [COUNT_BITS-1:0] tally_g_reg, tally_g_next;
    logic [COUNT_BITS-1:0] tally_t_reg, tally_t_next;
    logic [COUNT_BITS-1:0] tally_o_reg, tally_o_next;
    logic [7:0]            low_q_reg, low_q_next;
    logic [7:0]            high_q_reg, high_q_next;
    logic [LEN_BITS-1:0]   line_len_reg, line_len_next;
    logic [LEN_BITS-1:0]   short_reg, short_next;
    logic [LEN_BITS-1:0]   long_reg, long_next;
    logic                  out_valid_reg, out_valid_next;
    out_t                  out_reg, out_next;

    logic [LEN_BITS-1:0]   short_fin, long_fin;
    logic [PHRED_BITS-1:0] phred;
    logic                  out_free;

    assign empty    = !out_valid_reg;
    assign result   = out_reg;
    assign out_free = !out_valid_reg || pop;
    assign rd_en    = rd_valid && ((rd_op.kind != OP_END) || out_free);

    always_comb
    begin
        // a pending quality line closes into the lengths before the totals go out
        short_fin = short_reg;
        long_fin  = long_reg;
        if (rd_op.close_qual)
        begin
            if (line_len_reg < short_reg)
            begin
                short_fin = line_len_reg;
            end
            if (line_len_reg > long_reg)
            begin
                long_fin = line_len_reg;
            end
        end
        phred = PHRED_NONE;
        if (high_q_reg > QUAL_HIGH_LIMIT)
        begin
            phred = PHRED_64;
        end
        if (low_q_reg < QUAL_LOW_LIMIT)
        begin
            phred = PHRED_33;
        end
    end

    always_comb
    begin
        tally_a_next   = tally_a_reg;
        tally_c_next   = tally_c_reg;
        tally_g_next   = tally_g_reg;
        tally_t_next   = tally_t_reg;
        tally_o_next   = tally_o_reg;
        low_q_next     = low_q_reg;
        high_q_next    = high_q_reg;
        line_len_next  = line_len_reg;
        short_next     = short_reg;
        long_next      = long_reg;
        out_valid_next = out_valid_reg && !pop;
        out_next       = out_reg;
        if (rd_en)
        begin
            case (rd_op.kind)
                OP_A:
                begin
                    if (tally_a_reg != COUNT_MAX)
                        tally_a_next = tally_a_reg + COUNT_BITS'(1);
                end
                OP_C:
                begin
                    if (tally_c_reg != COUNT_MAX)
                        tally_c_next = tally_c_reg + COUNT_BITS'(1);
                end
                OP_G:
                begin
                    if (tally_g_reg != COUNT_MAX)
                        tally_g_next = tally_g_reg + COUNT_BITS'(1);
                end
                OP_T:
                begin
                    if (tally_t_reg != COUNT_MAX)
                        tally_t_next = tally_t_reg + COUNT_BITS'(1);
                end
                OP_OTHER:
                begin
                    if (tally_o_reg != COUNT_MAX)
                        tally_o_next = tally_o_reg + COUNT_BITS'(1);
                end
                OP_QUAL:
                begin
                    if (rd_op.data_byte < low_q_reg)
                        low_q_next = rd_op.data_byte;
                    if (rd_op.data_byte > high_q_reg)
                        high_q_next = rd_op.data_byte;
                    if (line_len_reg != LEN_MAX)
                        line_len_next = line_len_reg + LEN_BITS'(1);
                end
                OP_QCLOSE:
                begin
                    if (line_len_reg < short_reg)
                        short_next = line_len_reg;
                    if (line_len_reg > long_reg)
                        long_next = line_len_reg;
                    line_len_next = '0;
                end
                OP_END:
                begin
                    out_valid_next           = 1'b1;
                    out_next.count_a          = tally_a_reg;
                    out_next.count_c          = tally_c_reg;
                    out_next.count_g          = tally_g_reg;
                    out_next.count_t          = tally_t_reg;
                    out_next.count_other      = tally_o_reg;
                    out_next.min_quality_char = low_q_reg;
                    out_next.max_quality_char = high_q_reg;
                    out_next.min_quality_len  = short_fin;
                    out_next.max_quality_len  = long_fin;
                    out_next.phred_offset     = phred;
                    tally_a_next  = '0;
                    tally_c_next  = '0;
                    tally_g_next  = '0;
                    tally_t_next  = '0;
                    tally_o_next  = '0;
                    low_q_next    = QUAL_LOW_INIT;
                    high_q_next   = QUAL_HIGH_INIT;
                    line_len_next = '0;
                    short_next    = LEN_MAX;
                    long_next     = '0;
                end
                default:
                begin
                    out_valid_next = out_valid_reg && !pop;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tally_a_reg   <= '0;
            tally_c_reg   <= '0;
            tally_g_reg   <= '0;
            tally_t_reg   <= '0;
            tally_o_reg   <= '0;
            low_q_reg     <= QUAL_LOW_INIT;
            high_q_reg    <= QUAL_HIGH_INIT;
            line_len_reg  <= '0;
            short_reg     <= LEN_MAX;
            long_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            tally_a_reg   <= tally_a_next;
            tally_c_reg   <= tally_c_next;
            tally_g_reg   <= tally_g_next;
            tally_t_reg   <= tally_t_next;
            tally_o_reg   <= tally_o_next;
            low_q_reg     <= low_q_next;
            high_q_reg    <= high_q_next;
            line_len_reg  <= line_len_next;
            short_reg     <= short_next;
            long_reg      <= long_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    a_end_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_en && rd_op.kind == OP_END) |=> out_valid_reg)
        else $error("end request did not produce a result");

    a_end_clears_state: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_en && rd_op.kind == OP_END) |=>
            (tally_a_reg == '0 && line_len_reg == '0 && short_reg == LEN_MAX))
        else $error("statistics not cleared after end");

    a_quality_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (low_q_reg <= QUAL_LOW_INIT) && (high_q_reg >= QUAL_HIGH_INIT))
        else $error("quality range left its starting bounds");

    a_end_waits_for_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_valid && rd_op.kind == OP_END && out_valid_reg && !pop) |-> !rd_en)
        else $error("end request overwrote a waiting result");

endmodule

### sim/fastq_composition_stats_test.sv
// self-checking testbench for the fastq composition statistics block
module fastq_composition_stats_test;

    import fcs_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_REQUESTS = 350;
    localparam int PHASE_ENDS = 8;

    // running totals of one stream, recorded on each end request and checked against the popped result
    class composition_board;
        logic [1:0]            phase;
        logic [LEN_BITS-1:0]   run_len;
        bit                    open_line;
        logic [COUNT_BITS-1:0] n_a, n_c, n_g, n_t, n_other;
        logic [7:0]            q_low, q_high;
        logic [LEN_BITS-1:0]   len_min, len_max;
        out_t                  totals_due[$];
        int                    mismatches;

        function new();
            clear();
            mismatches = 0;
        endfunction

        function void clear();
            phase = PHASE_HEADER;
            run_len = '0;
            open_line = 1'b0;
            n_a = '0;
            n_c = '0;
            n_g = '0;
            n_t = '0;
            n_other = '0;
            q_low = QUAL_LOW_INIT;
            q_high = QUAL_HIGH_INIT;
            len_min = LEN_MAX;
            len_max = '0;
        endfunction

        function logic [COUNT_BITS-1:0] sat_inc(logic [COUNT_BITS-1:0] n);
            return (n == COUNT_MAX) ? n : n + 1'b1;
        endfunction

        function void end_line();
            if (phase == PHASE_QUAL)
            begin
                if (run_len > len_max)
                    len_max = run_len;
                if (run_len < len_min)
                    len_min = run_len;
            end
            phase = phase + 2'd1;
            run_len = '0;
            open_line = 1'b0;
        endfunction

        function void note_request(in_t req);
            out_t t;
            if (req.cmd == CMD_DATA)
            begin
                if (req.data_byte == CH_NL)
                    end_line();
                else
                begin
                    open_line = 1'b1;
                    if (req.data_byte != CH_CR)
                    begin
                        if (phase == PHASE_SEQ)
                        begin
                            case (req.data_byte)
                                CH_A:    n_a = sat_inc(n_a);
                                CH_C:    n_c = sat_inc(n_c);
                                CH_G:    n_g = sat_inc(n_g);
                                CH_T:    n_t = sat_inc(n_t);
                                default: n_other = sat_inc(n_other);
                            endcase
                        end
                        else if (phase == PHASE_QUAL)
                        begin
                            if (req.data_byte < q_low)
                                q_low = req.data_byte;
                            if (req.data_byte > q_high)
                                q_high = req.data_byte;
                            if (run_len != LEN_MAX)
                                run_len = run_len + 1'b1;
                        end
                    end
                end
            end
            else
            begin
                // a last line without newline is closed here
                if (open_line)
                    end_line();
                t.count_a = n_a;
                t.count_c = n_c;
                t.count_g = n_g;
                t.count_t = n_t;
                t.count_other = n_other;
                t.min_quality_char = q_low;
                t.max_quality_char = q_high;
                t.min_quality_len = len_min;
                t.max_quality_len = len_max;
                t.phred_offset = PHRED_NONE;
                if (q_high > QUAL_HIGH_LIMIT)
                    t.phred_offset = PHRED_64;
                if (q_low < QUAL_LOW_LIMIT)
                    t.phred_offset = PHRED_33;
                totals_due.push_back(t);
                clear();
            end
        endfunction

        function void check_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch on %s: expected %0d, got %0d", name, want, got);
            end
        endfunction

        function void check_totals(out_t got);
            out_t want;
            if (totals_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result with nothing expected: count_a %0d", got.count_a);
                return;
            end
            want = totals_due.pop_front();
            check_field("count_a", want.count_a, got.count_a);
            check_field("count_c", want.count_c, got.count_c);
            check_field("count_g", want.count_g, got.count_g);
            check_field("count_t", want.count_t, got.count_t);
            check_field("count_other", want.count_other, got.count_other);
            check_field("min_quality_char", want.min_quality_char, got.min_quality_char);
            check_field("max_quality_char", want.max_quality_char, got.max_quality_char);
            check_field("min_quality_len", want.min_quality_len, got.min_quality_len);
            check_field("max_quality_len", want.max_quality_len, got.max_quality_len);
            check_field("phred_offset", want.phred_offset, got.phred_offset);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic push;
    logic full;
    in_t  item;
    logic empty;
    logic pop;
    out_t result;

    composition_board board;
    int requests_sent = 0;
    int ends_sent = 0;
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    bit hold_request = 1'b0;
    int hold_left = 0;
    int cycles = 0;
    int idle_table[4] = '{0, 86, 0, 22};
    int stall_table[4] = '{0, 0, 86, 22};

    fastq_composition_stats uut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .item(item),
        .empty(empty),
        .pop(pop),
        .result(result)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task send_request(input in_t req);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        item <= req;
        @(posedge clk);
        while (full)
            @(posedge clk);
        board.note_request(req);
        requests_sent++;
        @(negedge clk);
    endtask

    task send_data(input logic [7:0] b);
        in_t r;
        r.cmd = CMD_DATA;
        r.data_byte = b;
        send_request(r);
    endtask

    task send_end();
        in_t r;
        r.cmd = CMD_END;
        r.data_byte = 8'($urandom_range(255));
        send_request(r);
        ends_sent++;
    endtask

    function logic [7:0] pick_base();
        int k;
        k = $urandom_range(19);
        if (k < 17)
        begin
            case (k % 4)
                0: return CH_A;
                1: return CH_C;
                2: return CH_G;
                default: return CH_T;
            endcase
        end
        else if (k == 17)
            return CH_CR;
        return 8'($urandom_range(255));
    endfunction

    // one stream of a few records, mostly well formed, then an end request
    task send_stream();
        int records;
        int seq_len;
        int q_len;
        logic [7:0] q_lo;
        logic [7:0] q_hi;
        records = $urandom_range(1, 3);
        case ($urandom_range(3))
            0: begin q_lo = 8'd33; q_hi = 8'd73; end
            1: begin q_lo = 8'd64; q_hi = 8'd104; end
            2: begin q_lo = 8'd59; q_hi = 8'd74; end
            default: begin q_lo = 8'd0; q_hi = 8'd255; end
        endcase
        for (int r = 0; r < records; r++)
        begin
            if ($urandom_range(99) < 8)
                repeat ($urandom_range(1, 4)) send_data(8'($urandom_range(255)));
            send_data("@");
            repeat ($urandom_range(0, 3)) send_data(8'($urandom_range(33, 126)));
            if ($urandom_range(9) == 0)
                send_data(CH_CR);
            send_data(CH_NL);
            seq_len = $urandom_range(0, 10);
            repeat (seq_len) send_data(pick_base());
            send_data(CH_NL);
            send_data("+");
            if ($urandom_range(9) == 0)
                send_data(CH_CR);
            send_data(CH_NL);
            q_len = ($urandom_range(9) < 8) ? seq_len : $urandom_range(0, 12);
            repeat (q_len)
            begin
                if ($urandom_range(19) == 0)
                    send_data(CH_CR);
                else
                    send_data(8'($urandom_range(q_hi, q_lo)));
            end
            // sometimes the last quality line is left open for the end request
            if (r < records - 1 || $urandom_range(9) < 7)
                send_data(CH_NL);
        end
        send_end();
    endtask

    initial
    begin
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request && hold_left == 0)
            begin
                hold_left = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            board.check_totals(result);
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        int start_requests;
        int start_ends;
        rst_n = 1'b0;
        push = 1'b0;
        item = '0;
        board = new();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // end on an empty stream
        send_end();
        // every base, extreme bytes and CR on the sequence line
        send_data("@");
        send_data(CH_NL);
        send_data(CH_A);
        send_data(CH_C);
        send_data(CH_G);
        send_data(CH_T);
        send_data(8'h00);
        send_data(8'hFF);
        send_data(CH_CR);
        send_data(CH_NL);
        send_data("+");
        send_data(CH_NL);
        // quality line left open, closed by the end request
        send_data(8'h00);
        send_data(8'hFF);
        send_data(CH_CR);
        send_end();
        // empty record with a zero-length quality line
        repeat (4) send_data(CH_NL);
        send_end();

        for (int p = 0; p < 4; p++)
        begin
            sender_idle_pct = idle_table[p];
            receiver_stall_pct = stall_table[p];
            if (p == 0)
                hold_request = 1'b1;
            start_requests = requests_sent;
            start_ends = ends_sent;
            while (requests_sent - start_requests < PHASE_REQUESTS
                   || ends_sent - start_ends < PHASE_ENDS)
                send_stream();
        end
        push <= 1'b0;

        while (board.totals_due.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (board.mismatches == 0 && board.totals_due.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
